[rtl/second_order_jet_alu_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the second-order jet ALU.
// They expect a clock named clk and an active-low reset named arst_n.
// ---------------------------------------------------------------------------
`ifndef SECOND_ORDER_JET_ALU_TOP_ASSERT_SVH
`define SECOND_ORDER_JET_ALU_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SOJ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sojalu assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SOJ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sojalu assertion failed");

`endif

[rtl/sojalu_pkg.sv]
// ---------------------------------------------------------------------------
// sojalu_pkg
// Shared types, codes and helpers of the second-order jet ALU.
// ---------------------------------------------------------------------------
package sojalu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_EXPONENT = 32;
	localparam int CNT_W = $clog2(MAX_EXPONENT + 1);
	localparam int QDEPTH = 2;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	typedef enum logic [2:0] {
		K_ADD = 3'd0,
		K_SUB = 3'd1,
		K_MUL = 3'd2,
		K_DIV = 3'd3,
		K_POW = 3'd4,
		K_NOP = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic signed [31:0] f;
		logic signed [31:0] s;
	} jet_t;

	typedef struct packed {
		kind_t            kind;
		jet_t             x;
		jet_t             y;
		logic [CNT_W-1:0] cnt;
		logic             exp_neg;
		logic             y_zero;
	} entry_t;

	function automatic logic signed [31:0] jet_pick(input jet_t jt, input logic [1:0] i);
		case (i)
			2'd0: return jt.v;
			2'd1: return jt.f;
			default: return jt.s;
		endcase
	endfunction

	function automatic jet_t jet_put(input jet_t jt, input logic [1:0] i,
		input logic signed [31:0] val);
		jet_t r;
		r = jt;
		case (i)
			2'd0: r.v = val;
			2'd1: r.f = val;
			default: r.s = val;
		endcase
		return r;
	endfunction

endpackage

[rtl/sojalu_front.sv]
// ---------------------------------------------------------------------------
// sojalu_front
// Accepts requests, decodes the opcode and clamps the exponent magnitude.
// ---------------------------------------------------------------------------
module sojalu_front import sojalu_pkg::*; (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] x_first,
	input  logic signed [31:0] x_second,
	input  logic signed [31:0] y_value,
	input  logic signed [31:0] y_first,
	input  logic signed [31:0] y_second,
	input  logic signed [6:0]  exponent,
	input  logic               full,
	output logic               push,
	output entry_t             push_data
);

	logic [6:0] emag;

	assign in_stall = full;
	assign push = in_valid && !full;

	always_comb begin
		emag = exponent[6] ? 7'(-exponent) : 7'(exponent);
		push_data.x = '{v: x_value, f: x_first, s: x_second};
		push_data.y = '{v: y_value, f: y_first, s: y_second};
		push_data.exp_neg = exponent[6];
		push_data.y_zero = (y_value == 32'sd0);
		push_data.cnt = (emag > 7'(MAX_EXPONENT)) ? CNT_W'(MAX_EXPONENT) : CNT_W'(emag);
		unique case (opcode)
			OP_ADD: push_data.kind = K_ADD;
			OP_SUB: push_data.kind = K_SUB;
			OP_MUL: push_data.kind = K_MUL;
			OP_DIV: push_data.kind = K_DIV;
			OP_POW: push_data.kind = K_POW;
			default: push_data.kind = K_NOP;
		endcase
	end

endmodule

[rtl/sojalu_queue.sv]
// ---------------------------------------------------------------------------
// sojalu_queue
// Short request queue between the front and the back.
// ---------------------------------------------------------------------------
module sojalu_queue import sojalu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output entry_t pop_data
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	entry_t          mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full = (count_q == CW'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/sojalu_back.sv]
// ---------------------------------------------------------------------------
// sojalu_back
// Sequencer that carries out one request with a shared multiplier and a
// bit-serial divider, and holds the result in an output register.
// ---------------------------------------------------------------------------
`include "second_order_jet_alu_top_assert.svh"

module sojalu_back import sojalu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  entry_t             q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] r_value,
	output logic signed [31:0] r_first,
	output logic signed [31:0] r_second,
	output logic [1:0]         status
);

	localparam int AW = 66 - FRAC_BITS;
	localparam int DW = AW + FRAC_BITS;
	localparam int DCW = $clog2(DW + 1);
	localparam logic signed [31:0] ONE = 32'sh1 << FRAC_BITS;
	localparam logic [63:0] RND = 64'd1 << (FRAC_BITS - 1);
	localparam logic signed [AW-1:0] SMAX = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] SMIN = AW'(-64'sd2147483648);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_ADD   = 10'b0000000010,
		S_MUL   = 10'b0000000100,
		S_ACC   = 10'b0000001000,
		S_DSET  = 10'b0000010000,
		S_DIV   = 10'b0000100000,
		S_DFIN  = 10'b0001000000,
		S_JEND  = 10'b0010000000,
		S_PTAIL = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t             state_q;
	kind_t              kind_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               sat_q;
	logic               dz_q;
	logic               div_mode_q;
	logic               pow_div_q;
	logic [1:0]         k_q;
	logic [1:0]         j_q;
	logic [DCW-1:0]     dcnt_q;
	logic               out_valid_q;

	jet_t               a_q;
	jet_t               b_q;
	jet_t               p_q;
	logic signed [AW-1:0] acc_q;
	logic [63:0]        prod_q;
	logic               pneg_q;
	logic [DW-1:0]      dvd_q;
	logic [31:0]        rem_q;
	logic [32:0]        quo_q;
	logic               ovf_q;
	logic               dneg_q;
	logic [31:0]        ud_q;
	logic signed [31:0] r_value_q;
	logic signed [31:0] r_first_q;
	logic signed [31:0] r_second_q;
	logic [1:0]         status_q;

	jet_t               one_j;
	logic signed [31:0] op1;
	logic signed [31:0] op2;
	logic [31:0]        m1;
	logic [31:0]        m2;
	logic [63:0]        rnd;
	logic signed [AW-1:0] term;
	logic signed [AW-1:0] acc_n;
	logic [32:0]        acc_sat;
	logic [32:0]        add_v;
	logic [32:0]        add_f;
	logic [32:0]        add_s;
	logic               is_sub;
	logic [32:0]        dt;
	logic               dge;
	logic [31:0]        rem_n;
	logic               rup;
	logic [32:0]        resm;
	logic signed [31:0] dval;
	logic               dsat;
	logic [AW-1:0]      un;
	logic               out_free;

	function automatic logic [32:0] sat_fn(input logic signed [AW-1:0] v);
		if (v > SMAX) begin
			return {1'b1, 32'h7fffffff};
		end else if (v < SMIN) begin
			return {1'b1, 32'h80000000};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic signed [AW-1:0] ext(input logic signed [31:0] x);
		return AW'(x);
	endfunction

	assign one_j = '{v: ONE, f: 32'sd0, s: 32'sd0};
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign r_value = r_value_q;
	assign r_first = r_first_q;
	assign r_second = r_second_q;
	assign status = status_q;

	always_comb begin
		op1 = div_mode_q ? jet_pick(p_q, j_q) : jet_pick(a_q, j_q);
		op2 = jet_pick(b_q, 2'(k_q - j_q));
		m1 = op1[31] ? 32'(-op1) : 32'(op1);
		m2 = op2[31] ? 32'(-op2) : 32'(op2);
		rnd = (prod_q + RND) >> FRAC_BITS;
		term = signed'(rnd[AW-1:0]);
		acc_n = (pneg_q ^ div_mode_q) ? acc_q - term : acc_q + term;
		acc_sat = sat_fn(acc_n);

		is_sub = (kind_q == K_SUB);
		add_v = sat_fn(is_sub ? ext(a_q.v) - ext(b_q.v) : ext(a_q.v) + ext(b_q.v));
		add_f = sat_fn(is_sub ? ext(a_q.f) - ext(b_q.f) : ext(a_q.f) + ext(b_q.f));
		add_s = sat_fn(is_sub ? ext(a_q.s) - ext(b_q.s) : ext(a_q.s) + ext(b_q.s));

		dt = {rem_q, dvd_q[DW-1]};
		dge = (dt >= {1'b0, ud_q});
		rem_n = dge ? 32'(dt - {1'b0, ud_q}) : dt[31:0];
		rup = ({rem_q, 1'b0} >= {1'b0, ud_q});
		resm = {1'b0, quo_q[31:0]} + 33'(rup);
		un = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);

		if (ovf_q || quo_q[32]) begin
			dsat = 1'b1;
			dval = dneg_q ? 32'sh80000000 : 32'sh7fffffff;
		end else if (!dneg_q) begin
			dsat = (resm > 33'h07fffffff);
			dval = dsat ? 32'sh7fffffff : signed'(resm[31:0]);
		end else begin
			dsat = (resm > 33'h080000000);
			dval = dsat ? 32'sh80000000 : signed'(32'(33'd0 - resm));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= K_NOP;
			cnt_q <= '0;
			neg_q <= 1'b0;
			sat_q <= 1'b0;
			dz_q <= 1'b0;
			div_mode_q <= 1'b0;
			pow_div_q <= 1'b0;
			k_q <= '0;
			j_q <= '0;
			dcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						kind_q <= q_data.kind;
						cnt_q <= q_data.cnt;
						neg_q <= q_data.exp_neg;
						sat_q <= 1'b0;
						dz_q <= 1'b0;
						k_q <= '0;
						j_q <= '0;
						pow_div_q <= 1'b0;
						div_mode_q <= (q_data.kind == K_DIV);
						unique case (q_data.kind) inside
							K_ADD, K_SUB: state_q <= S_ADD;
							K_MUL: state_q <= S_MUL;
							K_DIV: begin
								if (q_data.y_zero) begin
									dz_q <= 1'b1;
									state_q <= S_OUT;
								end else begin
									state_q <= S_DSET;
								end
							end
							K_POW: state_q <= (q_data.cnt == '0) ? S_PTAIL : S_MUL;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ADD: begin
					sat_q <= add_v[32] | add_f[32] | add_s[32];
					state_q <= S_OUT;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!div_mode_q) begin
						if (j_q == k_q) begin
							sat_q <= sat_q | acc_sat[32];
							j_q <= '0;
							if (k_q == 2'd2) begin
								state_q <= S_JEND;
							end else begin
								k_q <= 2'(k_q + 2'd1);
								state_q <= S_MUL;
							end
						end else begin
							j_q <= 2'(j_q + 2'd1);
							state_q <= S_MUL;
						end
					end else begin
						if (j_q == 2'(k_q - 2'd1)) begin
							state_q <= S_DSET;
						end else begin
							j_q <= 2'(j_q + 2'd1);
							state_q <= S_MUL;
						end
					end
				end
				S_DSET: begin
					dcnt_q <= DCW'(DW);
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= DCW'(dcnt_q - 1'b1);
					if (dcnt_q == DCW'(1)) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					sat_q <= sat_q | dsat;
					j_q <= '0;
					if (k_q == 2'd2) begin
						state_q <= S_JEND;
					end else begin
						k_q <= 2'(k_q + 2'd1);
						state_q <= S_MUL;
					end
				end
				S_JEND: begin
					k_q <= '0;
					j_q <= '0;
					if (kind_q == K_POW && !pow_div_q) begin
						cnt_q <= CNT_W'(cnt_q - 1'b1);
						state_q <= (cnt_q == CNT_W'(1)) ? S_PTAIL : S_MUL;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_PTAIL: begin
					if (!neg_q) begin
						state_q <= S_OUT;
					end else if (a_q.v == 32'sd0) begin
						dz_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						div_mode_q <= 1'b1;
						pow_div_q <= 1'b1;
						k_q <= '0;
						j_q <= '0;
						state_q <= S_DSET;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					a_q <= (q_data.kind == K_POW) ? one_j : q_data.x;
					b_q <= (q_data.kind == K_POW) ? q_data.x : q_data.y;
					p_q <= '0;
					acc_q <= (q_data.kind == K_DIV) ? ext(q_data.x.v) : '0;
				end
			end
			S_ADD: begin
				p_q <= '{v: signed'(add_v[31:0]), f: signed'(add_f[31:0]),
					s: signed'(add_s[31:0])};
			end
			S_MUL: begin
				prod_q <= 64'(m1) * 64'(m2);
				pneg_q <= op1[31] ^ op2[31];
			end
			S_ACC: begin
				if (!div_mode_q && j_q == k_q) begin
					p_q <= jet_put(p_q, k_q, signed'(acc_sat[31:0]));
					acc_q <= '0;
				end else begin
					acc_q <= acc_n;
				end
			end
			S_DSET: begin
				dvd_q <= {un, {FRAC_BITS{1'b0}}};
				ud_q <= b_q.v[31] ? 32'(-b_q.v) : 32'(b_q.v);
				dneg_q <= acc_q[AW-1] ^ b_q.v[31];
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			S_DIV: begin
				rem_q <= rem_n;
				quo_q <= {quo_q[31:0], dge};
				ovf_q <= ovf_q | quo_q[32];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
			S_DFIN: begin
				p_q <= jet_put(p_q, k_q, dval);
				acc_q <= ext(jet_pick(a_q, 2'(k_q + 2'd1)));
			end
			S_JEND: begin
				if (kind_q == K_POW && !pow_div_q) begin
					a_q <= p_q;
				end
				acc_q <= '0;
			end
			S_PTAIL: begin
				p_q <= a_q;
				b_q <= a_q;
				a_q <= one_j;
				acc_q <= ext(ONE);
			end
			S_OUT: begin
				if (out_free) begin
					r_value_q <= dz_q ? 32'sd0 : p_q.v;
					r_first_q <= dz_q ? 32'sd0 : p_q.f;
					r_second_q <= dz_q ? 32'sd0 : p_q.s;
					status_q <= dz_q ? ST_DZ : (sat_q ? ST_SAT : ST_OK);
				end
			end
			default: begin
			end
		endcase
	end

	`SOJ_ASSERT_IMP(a_dz_zero, out_valid_q && status_q == ST_DZ, ~|{r_value_q, r_first_q, r_second_q})
	`SOJ_ASSERT_IMP(a_k_range, state_q != S_IDLE, k_q != 2'd3)
	`SOJ_ASSERT_IMP(a_div_terms, state_q == S_MUL && div_mode_q, j_q < k_q)
	`SOJ_ASSERT_NXT(a_div_end, state_q == S_DIV && dcnt_q == DCW'(1), state_q == S_DFIN)

endmodule

[rtl/second_order_jet_alu_top.sv]
// Add and subtract pass through S_ADD; multiply sums the products for each output
// component in turn; divide forms three bit-serial quotients of a 66-bit dividend.
// Power multiplies by x once per unit of exponent, then takes the reciprocal if negative.
// One request is carried out at a time, so a new one starts right after the last;
// a stalled result holds the back sequencer in S_OUT until it is taken.
// Reset clears all control state asynchronously; no result is valid after reset.
// ---------------------------------------------------------------------------
// second_order_jet_alu_top
// Arithmetic on second-order truncated Taylor numbers in signed fixed point.
// ---------------------------------------------------------------------------
module second_order_jet_alu_top import sojalu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] x_first,
	input  logic signed [31:0] x_second,
	input  logic signed [31:0] y_value,
	input  logic signed [31:0] y_first,
	input  logic signed [31:0] y_second,
	input  logic signed [6:0]  exponent,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] r_value,
	output logic signed [31:0] r_first,
	output logic signed [31:0] r_second,
	output logic [1:0]         status
);

	logic   push;
	logic   full;
	logic   pop;
	logic   not_empty;
	entry_t push_data;
	entry_t pop_data;

	sojalu_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.x_value   (x_value),
		.x_first   (x_first),
		.x_second  (x_second),
		.y_value   (y_value),
		.y_first   (y_first),
		.y_second  (y_second),
		.exponent  (exponent),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	sojalu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	sojalu_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.r_value   (r_value),
		.r_first   (r_first),
		.r_second  (r_second),
		.status    (status)
	);

endmodule
